### rtl/i2cds_pkg.sv
`timescale 1ns / 1ps

package i2cds_pkg;

	localparam int BAUD_W    = 27;
	localparam int RATE_W    = 23;
	localparam int IDX_W     = 6;
	localparam int CODE_W    = 2;
	localparam int TBL_W     = 12;
	localparam int DIVISOR_W = 14;
	localparam int STEP_W    = 5;
	localparam int DIV_STEPS = 27;

	localparam logic [BAUD_W-1:0] BUS_CLOCK_RESET = 27'd24000000;
	localparam logic [STEP_W-1:0] LAST_STEP       = STEP_W'(DIV_STEPS - 1);

	// SCL divider table, one row per group of eight prescaler settings.
	localparam logic [TBL_W-1:0] SCL_DIV [64] = '{
		12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
		12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
		12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
		12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
		12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
		12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
		12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
		12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
	};

	typedef struct packed {
		logic              load_target;
		logic              load_div;
		logic              div_step;
		logic              eval;
		logic              first;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic exact;
	} status_t;

endpackage

### rtl/i2cds_ctrl.sv
`timescale 1ns / 1ps

module i2cds_ctrl #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MULT_CHOICES  = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output i2cds_pkg::cmd_t    cmd,
	input  i2cds_pkg::status_t status
);
	import i2cds_pkg::*;

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(MULT_CHOICES - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_EVAL = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CODE_W-1:0] code_q;
	logic [STEP_W-1:0] step_q;

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_FIN);

	always_comb begin
		cmd             = '0;
		cmd.idx         = idx_q;
		cmd.code        = code_q;
		cmd.first       = (idx_q == '0) && (code_q == '0);
		cmd.load_target = (state_q == ST_IDLE) && start;
		cmd.load_div    = (state_q == ST_LOAD);
		cmd.div_step    = (state_q == ST_DIV);
		cmd.eval        = (state_q == ST_EVAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			code_q  <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						code_q  <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_EVAL;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EVAL: begin
					// An exact match cannot be beaten, so the search ends there.
					if (status.exact || ((idx_q == LAST_IDX) && (code_q == LAST_CODE))) begin
						state_q <= ST_FIN;
					end else if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						code_q  <= code_q + 1'b1;
						state_q <= ST_LOAD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/i2cds_datapath.sv
`timescale 1ns / 1ps

module i2cds_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [i2cds_pkg::BAUD_W-1:0]     cfg_wr_data,
	input  logic [i2cds_pkg::BAUD_W-1:0]     target_baud,
	input  i2cds_pkg::cmd_t                  cmd,
	output i2cds_pkg::status_t               status,
	output logic [i2cds_pkg::IDX_W-1:0]      divider_index,
	output logic                             mult_code,
	output logic [7:0]                       freq_reg_byte,
	output logic [i2cds_pkg::RATE_W-1:0]     achieved_baud,
	output logic [i2cds_pkg::BAUD_W-1:0]     rate_error
);
	import i2cds_pkg::*;

	logic [BAUD_W-1:0]    bus_clock_q;
	logic [BAUD_W-1:0]    target_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [BAUD_W-1:0]    dq_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [CODE_W-1:0]    best_code_q;
	logic [RATE_W-1:0]    best_rate_q;
	logic [BAUD_W-1:0]    best_err_q;

	logic [DIVISOR_W:0]   trial;
	logic                 ge;
	logic [BAUD_W-1:0]    rate_ext;
	logic [BAUD_W-1:0]    err;
	logic                 take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clock_q <= BUS_CLOCK_RESET;
		end else if (cfg_wr_en) begin
			bus_clock_q <= cfg_wr_data;
		end
	end

	// Restoring division: the dividend shifts out of the top of dq_q while
	// quotient bits shift in at the bottom, one bit per cycle.
	assign trial = {rem_q, dq_q[BAUD_W-1]};
	assign ge    = (trial >= {1'b0, divisor_q});

	// The quotient never exceeds 23 bits since the smallest divisor is 20.
	assign rate_ext = {{(BAUD_W-RATE_W){1'b0}}, dq_q[RATE_W-1:0]};
	assign err      = (rate_ext > target_q) ? (rate_ext - target_q) : (target_q - rate_ext);
	assign take     = cmd.first || (err < best_err_q);
	assign status.exact = (err == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_target) begin
			target_q <= target_baud;
		end
		if (cmd.load_div) begin
			divisor_q <= DIVISOR_W'({2'b00, SCL_DIV[cmd.idx]} << cmd.code);
			rem_q     <= '0;
			dq_q      <= bus_clock_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? DIVISOR_W'(trial - {1'b0, divisor_q}) : trial[DIVISOR_W-1:0];
			dq_q  <= {dq_q[BAUD_W-2:0], ge};
		end
		if (cmd.eval && take) begin
			best_idx_q  <= cmd.idx;
			best_code_q <= cmd.code;
			best_rate_q <= dq_q[RATE_W-1:0];
			best_err_q  <= err;
		end
	end

	assign divider_index = best_idx_q;
	assign mult_code     = best_code_q[0];
	assign freq_reg_byte = {best_code_q, best_idx_q};
	assign achieved_baud = best_rate_q;
	assign rate_error    = best_err_q;

endmodule

### rtl/i2c_divider_search_top.sv
`timescale 1ns / 1ps
// The search tries N candidates between the accepting edge and the cycle in which done is high, where N is
// the number of candidates tried (up to TABLE_ENTRIES * MULT_CHOICES, 128 by default).
// Each candidate takes a load state, the steps of the bit-serial divider and one compare.
// The search ends early on an exact match. One transaction at a time; busy covers the search
// and the done cycle, so a new transaction is taken only after the done cycle of the last one.
// The receiver cannot stall. Reset clears the controller and sets the bus clock register to 24000000.

module i2c_divider_search_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MULT_CHOICES  = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [i2cds_pkg::BAUD_W-1:0] cfg_wr_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [i2cds_pkg::BAUD_W-1:0] target_baud,
	output logic                         done,
	output logic [i2cds_pkg::IDX_W-1:0]  divider_index,
	output logic                         mult_code,
	output logic [7:0]                   freq_reg_byte,
	output logic [i2cds_pkg::RATE_W-1:0] achieved_baud,
	output logic [i2cds_pkg::BAUD_W-1:0] rate_error
);
	import i2cds_pkg::*;

	cmd_t    cmd;
	status_t status;

	i2cds_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MULT_CHOICES  (MULT_CHOICES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	i2cds_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.target_baud   (target_baud),
		.cmd           (cmd),
		.status        (status),
		.divider_index (divider_index),
		.mult_code     (mult_code),
		.freq_reg_byte (freq_reg_byte),
		.achieved_baud (achieved_baud),
		.rate_error    (rate_error)
	);

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import i2cds_pkg::*;

	localparam int TABLE_ENTRIES   = 64;
	localparam int MULT_CHOICES    = 2;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int DRAIN_CYCLES    = 4000;
	localparam int RANDOM_PHASES   = 7;
	localparam int ITEMS_PER_PHASE = 17;
	localparam int NUM_DIRECTED    = 25;

	typedef enum logic {MULT_X1 = 1'b0, MULT_X2 = 1'b1} mult_code_e;
	typedef enum logic {ROW_ITEM = 1'b0, ROW_CFG = 1'b1} row_kind_e;

	typedef struct packed {
		logic [IDX_W-1:0]  divider_index;
		logic              mult_code;
		logic [7:0]        freq_reg_byte;
		logic [RATE_W-1:0] achieved_baud;
		logic [BAUD_W-1:0] rate_error;
	} divider_choice_t;

	typedef struct packed {
		row_kind_e         kind;
		logic [BAUD_W-1:0] value;
		logic              typed;
		logic [IDX_W-1:0]  idx;
		mult_code_e        code;
		logic [RATE_W-1:0] rate;
		logic [BAUD_W-1:0] err;
	} directed_row_t;

	// Rows with typed set carry a result that follows directly from the bus clock
	// in force; all other rows are checked against the predictor.
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		'{ROW_ITEM, 27'd1200000,    1'b1, 6'd0,  MULT_X1, 23'd1200000, 27'd0},
		'{ROW_ITEM, 27'd0,          1'b1, 6'd63, MULT_X2, 23'd3125,    27'd3125},
		'{ROW_ITEM, 27'h7FFFFFF,    1'b1, 6'd0,  MULT_X1, 23'd1200000, 27'd133017727},
		'{ROW_ITEM, 27'd600000,     1'b1, 6'd7,  MULT_X1, 23'd600000,  27'd0},
		'{ROW_ITEM, 27'd3125,       1'b1, 6'd63, MULT_X2, 23'd3125,    27'd0},
		'{ROW_ITEM, 27'd100000,     1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd400000,     1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_CFG,  27'd0,          1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd12345,      1'b1, 6'd0,  MULT_X1, 23'd0,       27'd12345},
		'{ROW_ITEM, 27'h7FFFFFF,    1'b1, 6'd0,  MULT_X1, 23'd0,       27'd134217727},
		'{ROW_ITEM, 27'd0,          1'b1, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_CFG,  27'h7FFFFFF,    1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd0,          1'b1, 6'd63, MULT_X2, 23'd17476,   27'd17476},
		'{ROW_ITEM, 27'h7FFFFFF,    1'b1, 6'd0,  MULT_X1, 23'd6710886, 27'd127506841},
		'{ROW_ITEM, 27'd1000000,    1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'h5555555,    1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'h2AAAAAA,    1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_CFG,  27'd1,          1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd0,          1'b1, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd1,          1'b1, 6'd0,  MULT_X1, 23'd0,       27'd1},
		'{ROW_CFG,  27'd100000000,  1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd100000000,  1'b1, 6'd0,  MULT_X1, 23'd5000000, 27'd95000000},
		'{ROW_ITEM, 27'd100000,     1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd400000,     1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0},
		'{ROW_ITEM, 27'd3400000,    1'b0, 6'd0,  MULT_X1, 23'd0,       27'd0}
	};

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [BAUD_W-1:0] cfg_wr_data = '0;
	logic              start       = 1'b0;
	logic [BAUD_W-1:0] target_baud = '0;
	logic              busy;
	logic              done;
	logic [IDX_W-1:0]  divider_index;
	logic              mult_code;
	logic [7:0]        freq_reg_byte;
	logic [RATE_W-1:0] achieved_baud;
	logic [BAUD_W-1:0] rate_error;

	logic [BAUD_W-1:0] bus_clock_model = BUS_CLOCK_RESET;
	divider_choice_t   pending_choices [$];
	int                mismatches = 0;

	i2c_divider_search_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MULT_CHOICES (MULT_CHOICES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.target_baud  (target_baud),
		.done         (done),
		.divider_index(divider_index),
		.mult_code    (mult_code),
		.freq_reg_byte(freq_reg_byte),
		.achieved_baud(achieved_baud),
		.rate_error   (rate_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Multipliers in ascending order, table in index order; only a strictly
	// smaller error replaces the current choice, so ties keep the earliest.
	function automatic divider_choice_t best_divider_choice(input logic [BAUD_W-1:0] bus_clk,
			input logic [BAUD_W-1:0] target);
		divider_choice_t best;
		int unsigned     best_err;
		int unsigned     div;
		int unsigned     rate;
		int unsigned     err;
		bit              found;
		best     = '0;
		best_err = 0;
		found    = 1'b0;
		for (int c = 0; c < MULT_CHOICES; c++) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				div  = int'(SCL_DIV[i]) << c;
				rate = bus_clk / div;
				err  = (rate > target) ? rate - target : target - rate;
				if (!found || err < best_err) begin
					found              = 1'b1;
					best_err           = err;
					best.divider_index = i[IDX_W-1:0];
					best.mult_code     = c[0];
					best.freq_reg_byte = {c[1:0], i[5:0]};
					best.achieved_baud = rate[RATE_W-1:0];
					best.rate_error    = err[BAUD_W-1:0];
				end
			end
		end
		return best;
	endfunction

	function automatic logic [BAUD_W-1:0] random_target(input logic [BAUD_W-1:0] bus_clk);
		int unsigned pick;
		int unsigned div;
		int unsigned rate;
		pick = $urandom_range(99);
		if (pick < 45) begin
			div  = int'(SCL_DIV[$urandom_range(TABLE_ENTRIES - 1)])
				<< $urandom_range(MULT_CHOICES - 1);
			rate = bus_clk / div;
			// Mostly exact hits, which cut the search short; otherwise a near miss.
			if ($urandom_range(3) != 0)
				return rate[BAUD_W-1:0];
			if ($urandom_range(1) && rate > 3)
				return BAUD_W'(rate - $urandom_range(1, 3));
			return BAUD_W'(rate + $urandom_range(1, 3));
		end
		if (pick < 75)
			return BAUD_W'($urandom_range(1, 5000000));
		if (pick < 90)
			return BAUD_W'($urandom);
		return BAUD_W'($urandom_range(50));
	endfunction

	function automatic logic [BAUD_W-1:0] random_bus_clock();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return BAUD_W'($urandom_range(1000000, 100000000));
		if (pick < 80)
			return BAUD_W'($urandom_range(1, 100000));
		return BAUD_W'($urandom);
	endfunction

	task automatic check_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Holds start high until the transaction is taken. Start is left high when
	// no gap follows, so the next call keeps it up without a glitch.
	task automatic send_target(input logic [BAUD_W-1:0] value, input bit typed,
			input divider_choice_t typed_choice, input bit allow_idle);
		start       <= 1'b1;
		target_baud <= value;
		do
			@(posedge clk);
		while (busy);
		pending_choices.push_back(typed ? typed_choice
			: best_divider_choice(bus_clock_model, value));
		if (allow_idle && $urandom_range(99) < 22) begin
			start <= 1'b0;
			if ($urandom_range(1)) begin
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_choices.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_bus_clock(input logic [BAUD_W-1:0] value);
		start <= 1'b0;
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en       <= 1'b0;
		bus_clock_model  = value;
	endtask

	always @(posedge clk) begin
		divider_choice_t want;
		if (arst_n && done) begin
			if (pending_choices.size() == 0) begin
				$display("%0t: result with no transaction pending, divider_index %0d, rate %0d",
					$time, divider_index, achieved_baud);
				mismatches++;
			end else begin
				want = pending_choices.pop_front();
				check_field("divider_index", want.divider_index, divider_index);
				check_field("mult_code", want.mult_code, mult_code);
				check_field("freq_reg_byte", want.freq_reg_byte, freq_reg_byte);
				check_field("achieved_baud", want.achieved_baud, achieved_baud);
				check_field("rate_error", want.rate_error, rate_error);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		directed_row_t   row;
		divider_choice_t typed_choice;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			row = DIRECTED[r];
			if (row.kind == ROW_CFG) begin
				write_bus_clock(row.value);
			end else begin
				typed_choice.divider_index = row.idx;
				typed_choice.mult_code     = row.code;
				typed_choice.freq_reg_byte = {1'b0, row.code, row.idx};
				typed_choice.achieved_baud = row.rate;
				typed_choice.rate_error    = row.err;
				send_target(row.value, row.typed, typed_choice, 1'b1);
			end
		end

		// One phase per bus clock setting; the middle phase runs back to back.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_bus_clock(phase == 0 ? BUS_CLOCK_RESET : random_bus_clock());
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_target(random_target(bus_clock_model), 1'b0, '0, phase != 3);
		end

		start <= 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_choices.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### i2c_divider_search_top.f
rtl/i2cds_pkg.sv
rtl/i2cds_ctrl.sv
rtl/i2cds_datapath.sv
rtl/i2c_divider_search_top.sv
test/testbench.sv
